>>> sv/s3ls_pkg.sv
`default_nettype none
package s3ls_pkg;

	// Field format
	localparam int VW = 32;
	localparam int FB = 16;

	// Internal widths: products, cofactors, dot products and their magnitudes
	localparam int PW = 2 * VW;
	localparam int CW = PW + 1;
	localparam int LW = 2 * VW + 1;
	localparam int DW = VW + CW + 1;
	localparam int MW = DW - 1;
	localparam int NW = MW + FB;
	localparam int QW = VW + 1;
	localparam int RW = MW + 1;

	typedef struct packed {
		logic signed [VW-1:0] a00;
		logic signed [VW-1:0] a01;
		logic signed [VW-1:0] a02;
		logic signed [VW-1:0] a10;
		logic signed [VW-1:0] a11;
		logic signed [VW-1:0] a12;
		logic signed [VW-1:0] a20;
		logic signed [VW-1:0] a21;
		logic signed [VW-1:0] a22;
		logic signed [VW-1:0] b0;
		logic signed [VW-1:0] b1;
		logic signed [VW-1:0] b2;
	} sys_t;

	typedef struct packed {
		logic signed [VW-1:0] x0;
		logic signed [VW-1:0] x1;
		logic signed [VW-1:0] x2;
		logic                 singular;
		logic                 overflow;
	} root_t;

endpackage
`default_nettype wire

>>> sv/s3ls_cof.sv
`default_nettype none
module s3ls_cof (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire s3ls_pkg::sys_t                    in_sys,
	output logic                                   out_valid,
	output logic signed [s3ls_pkg::CW-1:0]         cof [3][3],
	output logic signed [s3ls_pkg::VW-1:0]         row0 [3],
	output logic signed [s3ls_pkg::VW-1:0]         rhs [3]
);

	logic signed [s3ls_pkg::VW-1:0] am [3][3];
	logic signed [s3ls_pkg::VW-1:0] bm [3];
	logic signed [s3ls_pkg::PW-1:0] pa_s1 [3][3];
	logic signed [s3ls_pkg::PW-1:0] pb_s1 [3][3];
	logic signed [s3ls_pkg::VW-1:0] row0_s1 [3];
	logic signed [s3ls_pkg::VW-1:0] rhs_s1 [3];
	logic signed [s3ls_pkg::CW-1:0] cof_s2 [3][3];
	logic signed [s3ls_pkg::VW-1:0] row0_s2 [3];
	logic signed [s3ls_pkg::VW-1:0] rhs_s2 [3];
	logic                           vld_s1;
	logic                           vld_s2;

	// Unpack the item into a matrix
	always_comb begin
		am[0][0] = in_sys.a00; am[0][1] = in_sys.a01; am[0][2] = in_sys.a02;
		am[1][0] = in_sys.a10; am[1][1] = in_sys.a11; am[1][2] = in_sys.a12;
		am[2][0] = in_sys.a20; am[2][1] = in_sys.a21; am[2][2] = in_sys.a22;
		bm[0] = in_sys.b0; bm[1] = in_sys.b1; bm[2] = in_sys.b2;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: the two 2x2 minor products; stage 2: their difference
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int R0 = (i + 1) % 3;
			localparam int R1 = (i + 2) % 3;
			localparam int K0 = (j + 1) % 3;
			localparam int K1 = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s1[i][j]  <= am[R0][K0] * am[R1][K1];
					pb_s1[i][j]  <= am[R0][K1] * am[R1][K0];
					cof_s2[i][j] <= s3ls_pkg::CW'(pa_s1[i][j]) - s3ls_pkg::CW'(pb_s1[i][j]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				row0_s1[i] <= am[0][i];
				rhs_s1[i]  <= bm[i];
				row0_s2[i] <= row0_s1[i];
				rhs_s2[i]  <= rhs_s1[i];
			end
		end
	end

	assign out_valid = vld_s2;
	assign cof       = cof_s2;
	assign row0      = row0_s2;
	assign rhs       = rhs_s2;

endmodule
`default_nettype wire

>>> sv/s3ls_mac.sv
`default_nettype none
module s3ls_mac (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic signed [s3ls_pkg::CW-1:0]    cof [3][3],
	input  wire logic signed [s3ls_pkg::VW-1:0]    row0 [3],
	input  wire logic signed [s3ls_pkg::VW-1:0]    rhs [3],
	output logic                                   out_valid,
	output logic signed [s3ls_pkg::DW-1:0]         det,
	output logic signed [s3ls_pkg::DW-1:0]         num [3]
);

	// Terms 0..2 form the determinant, terms 3+3i+j form numerator i
	logic signed [s3ls_pkg::LW-1:0] lo_s3 [12];
	logic signed [s3ls_pkg::LW-1:0] hi_s3 [12];
	logic signed [s3ls_pkg::DW-1:0] term_s4 [12];
	logic signed [s3ls_pkg::DW-1:0] det_s5;
	logic signed [s3ls_pkg::DW-1:0] num_s5 [3];
	logic                           vld_s3;
	logic                           vld_s4;
	logic                           vld_s5;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_valid;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Split each wide cofactor into a low and a high half, multiply, recombine
	for (genvar t = 0; t < 12; t++) begin : g_term
		localparam int CI = (t < 3) ? 0 : (t - 3) % 3;
		localparam int CJ = (t < 3) ? t : (t - 3) / 3;
		logic signed [s3ls_pkg::VW-1:0] x;
		logic signed [s3ls_pkg::CW-1:0] c;
		if (t < 3) begin : g_det
			assign x = row0[t];
		end else begin : g_num
			assign x = rhs[CI];
		end
		assign c = cof[CI][CJ];
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s3[t]   <= x * $signed({1'b0, c[s3ls_pkg::VW-1:0]});
				hi_s3[t]   <= x * $signed(c[s3ls_pkg::CW-1:s3ls_pkg::VW]);
				term_s4[t] <= (s3ls_pkg::DW'(hi_s3[t]) <<< s3ls_pkg::VW)
					+ s3ls_pkg::DW'(lo_s3[t]);
			end
		end
	end

	// Sum three terms per dot product
	always_ff @(posedge clk) begin
		if (en) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= term_s4[3+3*i] + term_s4[4+3*i] + term_s4[5+3*i];
			end
		end
	end

	assign out_valid = vld_s5;
	assign det       = det_s5;
	assign num       = num_s5;

endmodule
`default_nettype wire

>>> sv/s3ls_div.sv
`default_nettype none
module s3ls_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              in_valid,
	input  wire logic signed [s3ls_pkg::DW-1:0]    num,
	input  wire logic signed [s3ls_pkg::DW-1:0]    det,
	output logic                                   out_valid,
	output logic signed [s3ls_pkg::VW-1:0]         root,
	output logic                                   singular,
	output logic                                   overflow
);

	localparam int QW = s3ls_pkg::QW;
	localparam logic [QW-1:0] QPOS = QW'((65'd1 << (s3ls_pkg::VW - 1)) - 65'd1);
	localparam logic [QW-1:0] QNEG = QW'(65'd1 << (s3ls_pkg::VW - 1));
	localparam logic [s3ls_pkg::VW-1:0] RMAX = {1'b0, {(s3ls_pkg::VW-1){1'b1}}};
	localparam logic [s3ls_pkg::VW-1:0] RMIN = {1'b1, {(s3ls_pkg::VW-1){1'b0}}};

	logic signed [s3ls_pkg::DW-1:0] nabs;
	logic signed [s3ls_pkg::DW-1:0] dabs;
	logic [s3ls_pkg::NW-1:0]        nsh;
	logic [s3ls_pkg::MW-1:0]        nmag_s1;
	logic [s3ls_pkg::MW-1:0]        dmag_s1;
	logic                           neg_s1;
	logic                           zero_s1;
	logic                           vld_s1;

	// Index k holds the state after stage 2+k: k = 0 is the set-up, then one
	// quotient bit per stage
	logic [s3ls_pkg::RW-1:0]        rem_s2 [QW+1];
	logic [QW-1:0]                  q_s2 [QW+1];
	logic [QW-1:0]                  nlo_s2 [QW+1];
	logic [s3ls_pkg::MW-1:0]        dmag_s2 [QW+1];
	logic                           big_s2 [QW+1];
	logic                           neg_s2 [QW+1];
	logic                           zero_s2 [QW+1];
	logic                           vld_s2 [QW+1];

	logic signed [s3ls_pkg::VW-1:0] root_s4;
	logic                           sing_s4;
	logic                           ovf_s4;
	logic                           vld_s4;

	// Stage 1: magnitudes, sign of the quotient, singular test
	assign nabs = num[s3ls_pkg::DW-1] ? -num : num;
	assign dabs = det[s3ls_pkg::DW-1] ? -det : det;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= nabs[s3ls_pkg::MW-1:0];
			dmag_s1 <= dabs[s3ls_pkg::MW-1:0];
			neg_s1  <= num[s3ls_pkg::DW-1] ^ det[s3ls_pkg::DW-1];
			zero_s1 <= (det == '0);
		end
	end

	// Stage 2: scale the numerator, flag a quotient too wide for QW bits
	assign nsh = {nmag_s1, {s3ls_pkg::FB{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else if (en) begin
			vld_s2[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2[0]  <= s3ls_pkg::RW'(nsh[s3ls_pkg::NW-1:QW]);
			big_s2[0]  <= s3ls_pkg::MW'(nsh[s3ls_pkg::NW-1:QW]) >= dmag_s1;
			q_s2[0]    <= '0;
			nlo_s2[0]  <= nsh[QW-1:0];
			dmag_s2[0] <= dmag_s1;
			neg_s2[0]  <= neg_s1;
			zero_s2[0] <= zero_s1;
		end
	end

	// Restoring division: one compare and subtract per stage
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [s3ls_pkg::RW-1:0] trial;
		logic                    ge;
		assign trial = {rem_s2[k][s3ls_pkg::RW-2:0], nlo_s2[k][QW-1-k]};
		assign ge    = trial >= s3ls_pkg::RW'(dmag_s2[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k+1] <= 1'b0;
			end else if (en) begin
				vld_s2[k+1] <= vld_s2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s2[k+1]  <= ge ? trial - s3ls_pkg::RW'(dmag_s2[k]) : trial;
				q_s2[k+1]    <= {q_s2[k][QW-2:0], ge};
				nlo_s2[k+1]  <= nlo_s2[k];
				dmag_s2[k+1] <= dmag_s2[k];
				big_s2[k+1]  <= big_s2[k];
				neg_s2[k+1]  <= neg_s2[k];
				zero_s2[k+1] <= zero_s2[k];
			end
		end
	end

	// Last stage: apply sign, saturate, force zero on a singular system
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s2[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s4 <= zero_s2[QW];
			if (zero_s2[QW]) begin
				root_s4 <= '0;
				ovf_s4  <= 1'b0;
			end else if (!neg_s2[QW]) begin
				if (big_s2[QW] || q_s2[QW] > QPOS) begin
					root_s4 <= RMAX;
					ovf_s4  <= 1'b1;
				end else begin
					root_s4 <= q_s2[QW][s3ls_pkg::VW-1:0];
					ovf_s4  <= 1'b0;
				end
			end else begin
				if (big_s2[QW] || q_s2[QW] > QNEG) begin
					root_s4 <= RMIN;
					ovf_s4  <= 1'b1;
				end else begin
					root_s4 <= ~q_s2[QW][s3ls_pkg::VW-1:0] + 1'b1;
					ovf_s4  <= 1'b0;
				end
			end
		end
	end

	assign out_valid = vld_s4;
	assign root      = root_s4;
	assign singular  = sing_s4;
	assign overflow  = ovf_s4;

endmodule
`default_nettype wire

>>> sv/solve_3x3_linear_system.sv
// Solves A*x = b for one 3x3 system in signed Q16.16 per item, by cofactors,
// determinant and one exact division per root rounded toward zero. A new
// item is taken every cycle unless a result waits at the output. The path
// is 41 register stages: 2 stages of minor products and cofactors, 3 stages
// of split 32x33 multiplies and sums, then a 36-stage divider per root
// (magnitudes, set-up, 33 quotient bits, one saturation stage). The whole
// pipeline halts while a result waits at the output. A zero determinant
// gives zero roots with singular set; a root beyond Q16.16 saturates and
// sets overflow.
`default_nettype none
module solve_3x3_linear_system (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire s3ls_pkg::sys_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output s3ls_pkg::root_t       out_data
);

	logic                           en;
	logic                           cof_valid;
	logic signed [s3ls_pkg::CW-1:0] cof [3][3];
	logic signed [s3ls_pkg::VW-1:0] row0 [3];
	logic signed [s3ls_pkg::VW-1:0] rhs [3];
	logic                           mac_valid;
	logic signed [s3ls_pkg::DW-1:0] det;
	logic signed [s3ls_pkg::DW-1:0] num [3];
	logic                           dv [3];
	logic signed [s3ls_pkg::VW-1:0] root [3];
	logic                           sing [3];
	logic                           ovf [3];

	// Advance the pipeline unless a result is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	s3ls_cof u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_sys    (in_data),
		.out_valid (cof_valid),
		.cof       (cof),
		.row0      (row0),
		.rhs       (rhs)
	);

	s3ls_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cof_valid),
		.cof       (cof),
		.row0      (row0),
		.rhs       (rhs),
		.out_valid (mac_valid),
		.det       (det),
		.num       (num)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		s3ls_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (mac_valid),
			.num       (num[i]),
			.det       (det),
			.out_valid (dv[i]),
			.root      (root[i]),
			.singular  (sing[i]),
			.overflow  (ovf[i])
		);
	end

	// Merge the three root lanes
	assign out_valid         = dv[0] & dv[1] & dv[2];
	assign out_data.x0       = root[0];
	assign out_data.x1       = root[1];
	assign out_data.x2       = root[2];
	assign out_data.singular = sing[0];
	assign out_data.overflow = ovf[0] | ovf[1] | ovf[2];

	// The three divider lanes stay in step
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(dv[0] == dv[1]) && (dv[1] == dv[2]))
		else $error("divider lanes out of step");

	// A singular system gives zero roots and no overflow
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |->
		!out_data.overflow && out_data.x0 == '0 && out_data.x1 == '0
		&& out_data.x2 == '0)
		else $error("singular result not cleared");

	// Overflow means some root sits at a Q16.16 limit
	a_overflow_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |->
		out_data.x0 == 32'sh7FFFFFFF || out_data.x0 == 32'sh80000000
		|| out_data.x1 == 32'sh7FFFFFFF || out_data.x1 == 32'sh80000000
		|| out_data.x2 == 32'sh7FFFFFFF || out_data.x2 == 32'sh80000000)
		else $error("overflow without saturated root");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  N_RANDOM   = 1230;
	localparam int  DRAIN_WAIT = 80;
	localparam int  CYCLE_CAP  = 400000;
	localparam int  HOLD_AT    = 400;
	localparam int  HOLD_LEN   = 300;
	localparam int  PAUSE_AT   = 650;
	localparam int  CALM_FROM  = 800;
	localparam int  CALM_TO    = 950;
	localparam logic signed [31:0] QMAX = 32'sh7fffffff;
	localparam logic signed [31:0] QMIN = 32'sh80000000;
	localparam logic signed [31:0] ONE  = 32'sh00010000;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		s3ls_pkg::sys_t  stim;
		bit              known;
		s3ls_pkg::root_t res;
	} row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	s3ls_pkg::sys_t  in_data = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	s3ls_pkg::root_t out_data;

	s3ls_pkg::root_t pending_roots[$];
	int    sent_count = 0;
	int    solved_count = 0;
	int    singular_seen = 0;
	int    overflow_seen = 0;
	int    fail_count = 0;
	int    cycles = 0;
	bit    calm = 1'b0;
	int    hold_left = 0;
	bit    hold_done = 1'b0;

	solve_3x3_linear_system uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact solve by cofactors at a width that never wraps
	function automatic s3ls_pkg::root_t solve_roots(s3ls_pkg::sys_t s);
		wide_t m[3][3];
		wide_t rhs[3];
		wide_t cof[3][3];
		wide_t det, num, q;
		logic signed [31:0] xs[3];
		s3ls_pkg::root_t r;
		r = '0;
		m[0][0] = $signed(s.a00); m[0][1] = $signed(s.a01); m[0][2] = $signed(s.a02);
		m[1][0] = $signed(s.a10); m[1][1] = $signed(s.a11); m[1][2] = $signed(s.a12);
		m[2][0] = $signed(s.a20); m[2][1] = $signed(s.a21); m[2][2] = $signed(s.a22);
		rhs[0] = $signed(s.b0); rhs[1] = $signed(s.b1); rhs[2] = $signed(s.b2);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
					- m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
		det = m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2];
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			num = cof[0][i] * rhs[0] + cof[1][i] * rhs[1] + cof[2][i] * rhs[2];
			num = num <<< s3ls_pkg::FB;
			q = num / det;
			if (q > wide_t'(QMAX)) begin
				xs[i] = QMAX;
				r.overflow = 1'b1;
			end else if (q < wide_t'(QMIN)) begin
				xs[i] = QMIN;
				r.overflow = 1'b1;
			end else begin
				xs[i] = q[31:0];
			end
		end
		r.x0 = xs[0]; r.x1 = xs[1]; r.x2 = xs[2];
		return r;
	endfunction

	function automatic s3ls_pkg::sys_t pack_system(logic signed [31:0] v[12]);
		return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
	endfunction

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return QMAX;
			1: return QMIN;
			2: return 32'sd0;
			3: return 32'sd1;
			4: return -32'sd1;
			5: return ONE;
			default: return -ONE;
		endcase
	endfunction

	// Mostly well-conditioned systems, with singular, extreme and raw noise mixed in
	function automatic s3ls_pkg::sys_t random_system();
		logic signed [31:0] v[12];
		int mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 12; k++) begin
			case (mode)
				0, 1, 2: v[k] = $urandom;
				8:       v[k] = pick_extreme();
				default: v[k] = $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			endcase
		end
		if (mode == 6) begin
			// copy row 0 into row 2
			v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
		end else if (mode == 7) begin
			// strengthen the diagonal
			v[0] = v[0] + 8 * ONE; v[4] = v[4] - 8 * ONE; v[8] = v[8] + 8 * ONE;
		end else if (mode == 9) begin
			// near identity with full-range right side
			for (int k = 0; k < 9; k++) v[k] = $signed($urandom_range(0, 255)) - 128;
			v[0] = v[0] + ONE; v[4] = v[4] + ONE; v[8] = v[8] + ONE;
			v[9] = $urandom; v[10] = $urandom; v[11] = $urandom;
		end
		return pack_system(v);
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item, hold it until accepted, then record what it must solve to
	task automatic send_system(s3ls_pkg::sys_t s, s3ls_pkg::root_t res);
		int gap;
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		pending_roots.push_back(res);
		sent_count++;
		gap = gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: random stalls, one long hold-off, a calm stretch
	always @(posedge clk) begin
		if (sent_count >= HOLD_AT && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 80);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		s3ls_pkg::root_t want;
		if (out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				$error("unexpected result x0=%h", out_data.x0);
				fail_count++;
			end else begin
				want = pending_roots.pop_front();
				solved_count++;
				if (want.singular) singular_seen++;
				if (want.overflow) overflow_seen++;
				if (out_data.x0 !== want.x0) begin
					$error("x0 expected %h got %h", want.x0, out_data.x0);
					fail_count++;
				end
				if (out_data.x1 !== want.x1) begin
					$error("x1 expected %h got %h", want.x1, out_data.x1);
					fail_count++;
				end
				if (out_data.x2 !== want.x2) begin
					$error("x2 expected %h got %h", want.x2, out_data.x2);
					fail_count++;
				end
				if (out_data.singular !== want.singular) begin
					$error("singular expected %b got %b", want.singular, out_data.singular);
					fail_count++;
				end
				if (out_data.overflow !== want.overflow) begin
					$error("overflow expected %b got %b", want.overflow, out_data.overflow);
					fail_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		row_t  rows[$];
		row_t  rw;
		logic signed [31:0] v[12];
		s3ls_pkg::root_t res;
		s3ls_pkg::sys_t  s;

		// zero matrix is singular
		rw.stim = '0; rw.known = 1'b1; rw.res = '0; rw.res.singular = 1'b1;
		rows.push_back(rw);
		// identity in Q16.16 returns b unchanged
		foreach (v[k]) v[k] = 0;
		v[0] = ONE; v[4] = ONE; v[8] = ONE;
		v[9] = ONE; v[10] = 2 * ONE; v[11] = -3 * ONE;
		rw.stim = pack_system(v); rw.res = '0;
		rw.res.x0 = ONE; rw.res.x1 = 2 * ONE; rw.res.x2 = -3 * ONE;
		rows.push_back(rw);
		v[9] = QMAX; v[10] = QMIN; v[11] = 0;
		rw.stim = pack_system(v); rw.res = '0;
		rw.res.x0 = QMAX; rw.res.x1 = QMIN; rw.res.x2 = 0;
		rows.push_back(rw);
		// tiny diagonal drives both roots into saturation
		v[0] = 1; v[4] = 1; v[8] = 1;
		rw.stim = pack_system(v); rw.res = '0;
		rw.res.x0 = QMAX; rw.res.x1 = QMIN; rw.res.x2 = 0; rw.res.overflow = 1'b1;
		rows.push_back(rw);
		// all fields at one extreme give rank one
		foreach (v[k]) v[k] = QMAX;
		rw.stim = pack_system(v); rw.res = '0; rw.res.singular = 1'b1;
		rows.push_back(rw);
		foreach (v[k]) v[k] = QMIN;
		rw.stim = pack_system(v);
		rows.push_back(rw);
		foreach (v[k]) v[k] = -1;
		rw.stim = pack_system(v);
		rows.push_back(rw);
		// extremes mixed, left to the predictor
		rw.known = 1'b0;
		for (int n = 0; n < 12; n++) begin
			foreach (v[k]) v[k] = pick_extreme();
			rw.stim = pack_system(v);
			rows.push_back(rw);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i]) begin
			res = rows[i].known ? rows[i].res : solve_roots(rows[i].stim);
			send_system(rows[i].stim, res);
		end

		// random systems
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				while (pending_roots.size() != 0) @(posedge clk);
			end
			calm = (n >= CALM_FROM && n < CALM_TO);
			s = random_system();
			send_system(s, solve_roots(s));
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("solved %0d systems, %0d singular, %0d with a saturated root",
			solved_count, singular_seen, overflow_seen);
		$display("including a long output hold-off and a drained pause; %0d failures",
			fail_count);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
sv/s3ls_pkg.sv
sv/s3ls_cof.sv
sv/s3ls_mac.sv
sv/s3ls_div.sv
sv/solve_3x3_linear_system.sv
tb/sv/testbench.sv
